// ===== hw/rtl/cotp_pkg.sv =====
// Shared constants and types for the outer tangent point pipeline.
// No dependencies; used by the top level and by its checker.
`default_nettype none

package cotp_pkg;

  // Field widths
  localparam int COORD_W = 24;
  localparam int RAD_W   = COORD_W - 1;

  // The largest normalised magnitude lies in [2^30, 2^31)
  localparam int NORM_W = 31;
  localparam int SH_W   = 5;
  localparam int SQ_W   = 2 * NORM_W;
  localparam int D2_W   = SQ_W + 1;

  // Integer square root, one result bit per stage
  localparam int ROOT_W     = 32;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int SREM_W     = ROOT_W + 3;

  // Unit vector components in Q30, one quotient bit per stage
  localparam int UNIT_BITS = 30;
  localparam int DIV_STEPS = UNIT_BITS + 1;
  localparam int Q_W       = DIV_STEPS;
  localparam int DREM_W    = D2_W + 1;
  localparam int LANES     = 4;

  // Products and sums
  localparam int PRD_W = NORM_W + ROOT_W;
  localparam int SUM_W = PRD_W + 2;
  localparam int SCL_W = RAD_W + Q_W;
  localparam int OUT_W = SCL_W - UNIT_BITS;
  localparam int PT_W  = COORD_W + 2;
  localparam int NPTS  = 8;

  // Start to strobe, in cycles
  localparam int LATENCY = 5 + SQRT_STEPS + 3 + DIV_STEPS + 2;

  // Centres and radii carried along the pipeline
  typedef struct packed {
    logic signed [COORD_W-1:0] c1x;
    logic signed [COORD_W-1:0] c1y;
    logic signed [COORD_W-1:0] c2x;
    logic signed [COORD_W-1:0] c2y;
    logic [RAD_W-1:0]          r1;
    logic [RAD_W-1:0]          r2;
  } geo_t;

  // Difference magnitudes and their signs
  typedef struct packed {
    logic [NORM_W-1:0] ax;
    logic [NORM_W-1:0] ay;
    logic [NORM_W-1:0] ar;
    logic              sx;
    logic              sy;
    logic              sr;
  } mag_t;

endpackage

`default_nettype wire

// ===== hw/rtl/circle_outer_tangent_points.sv =====
// Outer tangent touch points of two circles, fully pipelined.
// Depends on cotp_pkg (widths, stage counts, carried types).
//
//   channel  | ports                         | handshake
//   ---------+-------------------------------+------------------------------
//   input    | start, busy, in_*             | taken when start & !busy
//   result   | out_valid, out_*              | one-cycle strobe, no back-pressure
//
// One transaction enters per cycle once out of reset. The depth is set by the
// square root (32 stages, one root bit each) and the four parallel dividers
// (31 stages, one quotient bit each).
// Synchronous reset clears all valid bits; busy is high only while in reset.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none

module circle_outer_tangent_points (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [cotp_pkg::COORD_W-1:0] in_first_center_x,
  input  logic signed [cotp_pkg::COORD_W-1:0] in_first_center_y,
  input  logic        [cotp_pkg::RAD_W-1:0]   in_first_radius,
  input  logic signed [cotp_pkg::COORD_W-1:0] in_second_center_x,
  input  logic signed [cotp_pkg::COORD_W-1:0] in_second_center_y,
  input  logic        [cotp_pkg::RAD_W-1:0]   in_second_radius,
  output logic                                out_valid,
  output logic signed [cotp_pkg::COORD_W-1:0] out_cw_first_x,
  output logic signed [cotp_pkg::COORD_W-1:0] out_cw_first_y,
  output logic signed [cotp_pkg::COORD_W-1:0] out_cw_second_x,
  output logic signed [cotp_pkg::COORD_W-1:0] out_cw_second_y,
  output logic signed [cotp_pkg::COORD_W-1:0] out_ccw_first_x,
  output logic signed [cotp_pkg::COORD_W-1:0] out_ccw_first_y,
  output logic signed [cotp_pkg::COORD_W-1:0] out_ccw_second_x,
  output logic signed [cotp_pkg::COORD_W-1:0] out_ccw_second_y,
  output logic                                out_degenerate
);

  // Saturate a widened point to the coordinate range
  function automatic logic signed [cotp_pkg::COORD_W-1:0] sat_pt(
    input logic signed [cotp_pkg::PT_W-1:0] v);
    logic signed [cotp_pkg::PT_W-1:0] hi;
    logic signed [cotp_pkg::PT_W-1:0] lo;
    hi = (cotp_pkg::PT_W)'((1 << (cotp_pkg::COORD_W - 1)) - 1);
    lo = -hi - (cotp_pkg::PT_W)'(1);
    if (v > hi) begin
      sat_pt = hi[cotp_pkg::COORD_W-1:0];
    end else if (v < lo) begin
      sat_pt = lo[cotp_pkg::COORD_W-1:0];
    end else begin
      sat_pt = v[cotp_pkg::COORD_W-1:0];
    end
  endfunction

  // Busy only while held in reset
  logic busy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) busy_r <= 1'b1;
    else        busy_r <= 1'b0;
  end
  assign busy = busy_r;

  // ---------------- Stage 1: differences and magnitudes ----------------
  logic signed [cotp_pkg::COORD_W:0]   dx_s1, dy_s1;
  logic signed [cotp_pkg::COORD_W-1:0] dr_s1;
  logic [cotp_pkg::COORD_W:0]          axf_s1, ayf_s1;
  logic [cotp_pkg::COORD_W-1:0]        arf_s1;
  cotp_pkg::geo_t                      geo_s1;
  cotp_pkg::mag_t                      mag_s1;

  assign dx_s1 = (cotp_pkg::COORD_W+1)'(in_second_center_x)
               - (cotp_pkg::COORD_W+1)'(in_first_center_x);
  assign dy_s1 = (cotp_pkg::COORD_W+1)'(in_second_center_y)
               - (cotp_pkg::COORD_W+1)'(in_first_center_y);
  assign dr_s1 = $signed({1'b0, in_first_radius}) - $signed({1'b0, in_second_radius});

  always_comb begin
    axf_s1 = dx_s1[cotp_pkg::COORD_W] ? -dx_s1 : dx_s1;
    ayf_s1 = dy_s1[cotp_pkg::COORD_W] ? -dy_s1 : dy_s1;
    arf_s1 = dr_s1[cotp_pkg::COORD_W-1] ? -dr_s1 : dr_s1;
    geo_s1.c1x = in_first_center_x;
    geo_s1.c1y = in_first_center_y;
    geo_s1.c2x = in_second_center_x;
    geo_s1.c2y = in_second_center_y;
    geo_s1.r1  = in_first_radius;
    geo_s1.r2  = in_second_radius;
    mag_s1.ax  = (cotp_pkg::NORM_W)'(axf_s1[cotp_pkg::COORD_W-1:0]);
    mag_s1.ay  = (cotp_pkg::NORM_W)'(ayf_s1[cotp_pkg::COORD_W-1:0]);
    mag_s1.ar  = (cotp_pkg::NORM_W)'(arf_s1);
    mag_s1.sx  = dx_s1[cotp_pkg::COORD_W];
    mag_s1.sy  = dy_s1[cotp_pkg::COORD_W];
    mag_s1.sr  = dr_s1[cotp_pkg::COORD_W-1];
  end

  logic           v1_r;
  cotp_pkg::geo_t geo1_r;
  cotp_pkg::mag_t mag1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= start & ~busy_r;
    geo1_r <= geo_s1;
    mag1_r <= mag_s1;
  end

  // ---------------- Stage 2: normalising shift amount ----------------
  logic [cotp_pkg::COORD_W-1:0] m_s2;
  logic [cotp_pkg::SH_W-1:0]    msb_s2;

  always_comb begin
    m_s2 = mag1_r.ax[cotp_pkg::COORD_W-1:0];
    if (mag1_r.ay[cotp_pkg::COORD_W-1:0] > m_s2) m_s2 = mag1_r.ay[cotp_pkg::COORD_W-1:0];
    if (mag1_r.ar[cotp_pkg::COORD_W-1:0] > m_s2) m_s2 = mag1_r.ar[cotp_pkg::COORD_W-1:0];
    msb_s2 = '0;
    for (int i = 0; i < cotp_pkg::COORD_W; i++) begin
      if (m_s2[i]) msb_s2 = (cotp_pkg::SH_W)'(i);
    end
  end

  logic                      v2_r;
  cotp_pkg::geo_t            geo2_r;
  cotp_pkg::mag_t            mag2_r;
  logic [cotp_pkg::SH_W-1:0] sh2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    geo2_r <= geo1_r;
    mag2_r <= mag1_r;
    sh2_r  <= (cotp_pkg::SH_W)'(cotp_pkg::NORM_W - 1) - msb_s2;
  end

  // ---------------- Stage 3: apply shift ----------------
  cotp_pkg::mag_t mag_s3;
  always_comb begin
    mag_s3    = mag2_r;
    mag_s3.ax = mag2_r.ax << sh2_r;
    mag_s3.ay = mag2_r.ay << sh2_r;
    mag_s3.ar = mag2_r.ar << sh2_r;
  end

  logic           v3_r;
  cotp_pkg::geo_t geo3_r;
  cotp_pkg::mag_t mag3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
    geo3_r <= geo2_r;
    mag3_r <= mag_s3;
  end

  // ---------------- Stage 4: squares ----------------
  logic                      v4_r;
  cotp_pkg::geo_t            geo4_r;
  cotp_pkg::mag_t            mag4_r;
  logic [cotp_pkg::SQ_W-1:0] sqx4_r, sqy4_r, sqr4_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= v3_r;
    geo4_r <= geo3_r;
    mag4_r <= mag3_r;
    sqx4_r <= mag3_r.ax * mag3_r.ax;
    sqy4_r <= mag3_r.ay * mag3_r.ay;
    sqr4_r <= mag3_r.ar * mag3_r.ar;
  end

  // ---------------- Stage 5: d2, degenerate test, radicand ----------------
  logic [cotp_pkg::D2_W-1:0] d2_s5, rad_s5;
  logic                      deg_s5;
  assign d2_s5  = (cotp_pkg::D2_W)'(sqx4_r) + (cotp_pkg::D2_W)'(sqy4_r);
  assign deg_s5 = (d2_s5 == '0) || ((cotp_pkg::D2_W)'(sqr4_r) > d2_s5);
  assign rad_s5 = d2_s5 - (cotp_pkg::D2_W)'(sqr4_r);

  // Square root pipeline registers, entry s feeds step s
  logic                          sq_vld_r  [0:cotp_pkg::SQRT_STEPS];
  cotp_pkg::geo_t                sq_geo_r  [0:cotp_pkg::SQRT_STEPS];
  cotp_pkg::mag_t                sq_mag_r  [0:cotp_pkg::SQRT_STEPS];
  logic [cotp_pkg::D2_W-1:0]     sq_d2_r   [0:cotp_pkg::SQRT_STEPS];
  logic                          sq_deg_r  [0:cotp_pkg::SQRT_STEPS];
  logic [2*cotp_pkg::ROOT_W-1:0] sq_v_r    [0:cotp_pkg::SQRT_STEPS];
  logic [cotp_pkg::SREM_W-1:0]   sq_rem_r  [0:cotp_pkg::SQRT_STEPS];
  logic [cotp_pkg::ROOT_W-1:0]   sq_root_r [0:cotp_pkg::SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) sq_vld_r[0] <= 1'b0;
    else        sq_vld_r[0] <= v4_r;
    sq_geo_r[0]  <= geo4_r;
    sq_mag_r[0]  <= mag4_r;
    sq_d2_r[0]   <= d2_s5;
    sq_deg_r[0]  <= deg_s5;
    sq_v_r[0]    <= (2*cotp_pkg::ROOT_W)'(rad_s5);
    sq_rem_r[0]  <= '0;
    sq_root_r[0] <= '0;
  end

  // One root bit per stage, two radicand bits brought down each time
  for (genvar s = 0; s < cotp_pkg::SQRT_STEPS; s++) begin : g_sqrt
    logic [cotp_pkg::SREM_W-1:0] rem_sh;
    logic [cotp_pkg::SREM_W-1:0] trial;
    logic                        ge;
    logic [cotp_pkg::SREM_W-1:0] rem_nxt;
    logic [cotp_pkg::ROOT_W-1:0] root_nxt;

    always_comb begin
      rem_sh   = {sq_rem_r[s][cotp_pkg::SREM_W-3:0],
                  sq_v_r[s][2*cotp_pkg::ROOT_W-1-2*s -: 2]};
      trial    = (cotp_pkg::SREM_W)'({sq_root_r[s], 2'b01});
      ge       = rem_sh >= trial;
      rem_nxt  = ge ? rem_sh - trial : rem_sh;
      root_nxt = {sq_root_r[s][cotp_pkg::ROOT_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) sq_vld_r[s+1] <= 1'b0;
      else        sq_vld_r[s+1] <= sq_vld_r[s];
      sq_geo_r[s+1]  <= sq_geo_r[s];
      sq_mag_r[s+1]  <= sq_mag_r[s];
      sq_d2_r[s+1]   <= sq_d2_r[s];
      sq_deg_r[s+1]  <= sq_deg_r[s];
      sq_v_r[s+1]    <= sq_v_r[s];
      sq_rem_r[s+1]  <= rem_nxt;
      sq_root_r[s+1] <= root_nxt;
    end
  end

  // ---------------- Stage 6: cross products ----------------
  logic                       v6_r;
  cotp_pkg::geo_t             geo6_r;
  cotp_pkg::mag_t             mag6_r;
  logic [cotp_pkg::D2_W-1:0]  d2_6_r;
  logic                       deg6_r;
  logic [cotp_pkg::PRD_W-1:0] p_axar6_r, p_ayh6_r, p_axh6_r, p_ayar6_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else        v6_r <= sq_vld_r[cotp_pkg::SQRT_STEPS];
    geo6_r    <= sq_geo_r[cotp_pkg::SQRT_STEPS];
    mag6_r    <= sq_mag_r[cotp_pkg::SQRT_STEPS];
    d2_6_r    <= sq_d2_r[cotp_pkg::SQRT_STEPS];
    deg6_r    <= sq_deg_r[cotp_pkg::SQRT_STEPS];
    p_axar6_r <= sq_mag_r[cotp_pkg::SQRT_STEPS].ax * sq_mag_r[cotp_pkg::SQRT_STEPS].ar;
    p_ayh6_r  <= sq_mag_r[cotp_pkg::SQRT_STEPS].ay * sq_root_r[cotp_pkg::SQRT_STEPS];
    p_axh6_r  <= sq_mag_r[cotp_pkg::SQRT_STEPS].ax * sq_root_r[cotp_pkg::SQRT_STEPS];
    p_ayar6_r <= sq_mag_r[cotp_pkg::SQRT_STEPS].ay * sq_mag_r[cotp_pkg::SQRT_STEPS].ar;
  end

  // ---------------- Stage 7: signed numerators ----------------
  // lanes: cw x, cw y, ccw x, ccw y
  logic signed [cotp_pkg::SUM_W-1:0] t1_s7, t2_s7, t3_s7, t4_s7;
  always_comb begin
    t1_s7 = $signed((cotp_pkg::SUM_W)'(p_axar6_r));
    t2_s7 = $signed((cotp_pkg::SUM_W)'(p_ayh6_r));
    t3_s7 = $signed((cotp_pkg::SUM_W)'(p_axh6_r));
    t4_s7 = $signed((cotp_pkg::SUM_W)'(p_ayar6_r));
    if (mag6_r.sx ^ mag6_r.sr) t1_s7 = -t1_s7;
    if (mag6_r.sy)             t2_s7 = -t2_s7;
    if (mag6_r.sx)             t3_s7 = -t3_s7;
    if (mag6_r.sy ^ mag6_r.sr) t4_s7 = -t4_s7;
  end

  logic                              v7_r;
  cotp_pkg::geo_t                    geo7_r;
  logic [cotp_pkg::D2_W-1:0]         d2_7_r;
  logic                              deg7_r;
  logic signed [cotp_pkg::SUM_W-1:0] num7_r [cotp_pkg::LANES];
  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else        v7_r <= v6_r;
    geo7_r    <= geo6_r;
    d2_7_r    <= d2_6_r;
    deg7_r    <= deg6_r;
    num7_r[0] <= t1_s7 + t2_s7;
    num7_r[1] <= t4_s7 - t3_s7;
    num7_r[2] <= t1_s7 - t2_s7;
    num7_r[3] <= t3_s7 + t4_s7;
  end

  // ---------------- Stage 8 and divider pipeline ----------------
  logic                        dv_vld_r [0:cotp_pkg::DIV_STEPS];
  cotp_pkg::geo_t              dv_geo_r [0:cotp_pkg::DIV_STEPS];
  logic [cotp_pkg::D2_W-1:0]   dv_den_r [0:cotp_pkg::DIV_STEPS];
  logic                        dv_deg_r [0:cotp_pkg::DIV_STEPS];
  logic [cotp_pkg::LANES-1:0]  dv_neg_r [0:cotp_pkg::DIV_STEPS];
  logic [cotp_pkg::DREM_W-1:0] dv_rem_r [0:cotp_pkg::DIV_STEPS][cotp_pkg::LANES];
  logic [cotp_pkg::Q_W-1:0]    dv_q_r   [0:cotp_pkg::DIV_STEPS][cotp_pkg::LANES];

  // Magnitude and sign of each numerator
  logic [cotp_pkg::SUM_W-1:0] nmag_s8 [cotp_pkg::LANES];
  always_comb begin
    for (int l = 0; l < cotp_pkg::LANES; l++) begin
      nmag_s8[l] = num7_r[l][cotp_pkg::SUM_W-1] ? -num7_r[l] : num7_r[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv_vld_r[0] <= 1'b0;
    else        dv_vld_r[0] <= v7_r;
    dv_geo_r[0] <= geo7_r;
    dv_den_r[0] <= d2_7_r;
    dv_deg_r[0] <= deg7_r;
    for (int l = 0; l < cotp_pkg::LANES; l++) begin
      dv_neg_r[0][l] <= num7_r[l][cotp_pkg::SUM_W-1];
      dv_rem_r[0][l] <= (cotp_pkg::DREM_W)'(nmag_s8[l][cotp_pkg::D2_W-1:0]);
      dv_q_r[0][l]   <= '0;
    end
  end

  // Restoring division, one quotient bit per stage in each lane
  for (genvar k = 0; k < cotp_pkg::DIV_STEPS; k++) begin : g_div
    logic [cotp_pkg::DREM_W-1:0] rem_nxt [cotp_pkg::LANES];
    logic [cotp_pkg::Q_W-1:0]    q_nxt   [cotp_pkg::LANES];

    for (genvar l = 0; l < cotp_pkg::LANES; l++) begin : g_lane
      logic [cotp_pkg::DREM_W-1:0] cand;
      logic                        ge;
      always_comb begin
        if (k == 0) cand = dv_rem_r[k][l];
        else        cand = {dv_rem_r[k][l][cotp_pkg::DREM_W-2:0], 1'b0};
        ge         = cand >= (cotp_pkg::DREM_W)'(dv_den_r[k]);
        rem_nxt[l] = ge ? cand - (cotp_pkg::DREM_W)'(dv_den_r[k]) : cand;
        q_nxt[l]   = {dv_q_r[k][l][cotp_pkg::Q_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dv_vld_r[k+1] <= 1'b0;
      else        dv_vld_r[k+1] <= dv_vld_r[k];
      dv_geo_r[k+1] <= dv_geo_r[k];
      dv_den_r[k+1] <= dv_den_r[k];
      dv_deg_r[k+1] <= dv_deg_r[k];
      dv_neg_r[k+1] <= dv_neg_r[k];
      for (int l = 0; l < cotp_pkg::LANES; l++) begin
        dv_rem_r[k+1][l] <= rem_nxt[l];
        dv_q_r[k+1][l]   <= q_nxt[l];
      end
    end
  end

  // ---------------- Stage 9: scale by radius ----------------
  // point j: bit 0 picks y, bit 1 picks second circle, bit 2 picks ccw side
  logic                                v9_r;
  logic                                deg9_r;
  logic [cotp_pkg::SCL_W-1:0]          sc9_r  [cotp_pkg::NPTS];
  logic                                neg9_r [cotp_pkg::NPTS];
  logic signed [cotp_pkg::COORD_W-1:0] cen9_r [cotp_pkg::NPTS];

  always_ff @(posedge clk) begin
    if (!rst_n) v9_r <= 1'b0;
    else        v9_r <= dv_vld_r[cotp_pkg::DIV_STEPS];
    deg9_r <= dv_deg_r[cotp_pkg::DIV_STEPS];
  end

  for (genvar j = 0; j < cotp_pkg::NPTS; j++) begin : g_scale
    localparam int LN  = (j / 4) * 2 + (j % 2);
    localparam bit SEC = ((j / 2) % 2) == 1;
    localparam bit YC  = (j % 2) == 1;
    logic [cotp_pkg::RAD_W-1:0]          rad;
    logic signed [cotp_pkg::COORD_W-1:0] cen;
    always_comb begin
      rad = SEC ? dv_geo_r[cotp_pkg::DIV_STEPS].r2 : dv_geo_r[cotp_pkg::DIV_STEPS].r1;
      if (SEC) cen = YC ? dv_geo_r[cotp_pkg::DIV_STEPS].c2y : dv_geo_r[cotp_pkg::DIV_STEPS].c2x;
      else     cen = YC ? dv_geo_r[cotp_pkg::DIV_STEPS].c1y : dv_geo_r[cotp_pkg::DIV_STEPS].c1x;
    end
    always_ff @(posedge clk) begin
      sc9_r[j]  <= rad * dv_q_r[cotp_pkg::DIV_STEPS][LN];
      neg9_r[j] <= dv_neg_r[cotp_pkg::DIV_STEPS][LN];
      cen9_r[j] <= cen;
    end
  end

  // ---------------- Stage 10: round, add centre, saturate ----------------
  logic                                v10_r;
  logic                                deg10_r;
  logic signed [cotp_pkg::COORD_W-1:0] pt10_r [cotp_pkg::NPTS];

  for (genvar j = 0; j < cotp_pkg::NPTS; j++) begin : g_out
    logic [cotp_pkg::SCL_W:0]          rnd;
    logic signed [cotp_pkg::PT_W-1:0]  off;
    logic signed [cotp_pkg::PT_W-1:0]  sum;
    always_comb begin
      rnd = (cotp_pkg::SCL_W+1)'(sc9_r[j])
          + ((cotp_pkg::SCL_W+1)'(1) << (cotp_pkg::UNIT_BITS - 1));
      off = $signed((cotp_pkg::PT_W)'(rnd[cotp_pkg::SCL_W:cotp_pkg::UNIT_BITS]));
      if (neg9_r[j]) off = -off;
      sum = (cotp_pkg::PT_W)'(cen9_r[j]) + off;
    end
    always_ff @(posedge clk) begin
      pt10_r[j] <= deg9_r ? '0 : sat_pt(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v10_r <= 1'b0;
    else        v10_r <= v9_r;
    deg10_r <= deg9_r;
  end

  assign out_valid        = v10_r;
  assign out_degenerate   = deg10_r;
  assign out_cw_first_x   = pt10_r[0];
  assign out_cw_first_y   = pt10_r[1];
  assign out_cw_second_x  = pt10_r[2];
  assign out_cw_second_y  = pt10_r[3];
  assign out_ccw_first_x  = pt10_r[4];
  assign out_ccw_first_y  = pt10_r[5];
  assign out_ccw_second_x = pt10_r[6];
  assign out_ccw_second_y = pt10_r[7];

endmodule

`default_nettype wire

// ===== hw/rtl/cotp_checker.sv =====
// Port-level checks for circle_outer_tangent_points, bound to the top level.
// Depends on cotp_pkg for the coordinate width and the pipeline latency.
`default_nettype none

module cotp_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic                                out_valid,
  input logic signed [cotp_pkg::COORD_W-1:0] out_cw_first_x,
  input logic signed [cotp_pkg::COORD_W-1:0] out_cw_first_y,
  input logic signed [cotp_pkg::COORD_W-1:0] out_cw_second_x,
  input logic signed [cotp_pkg::COORD_W-1:0] out_cw_second_y,
  input logic signed [cotp_pkg::COORD_W-1:0] out_ccw_first_x,
  input logic signed [cotp_pkg::COORD_W-1:0] out_ccw_first_y,
  input logic signed [cotp_pkg::COORD_W-1:0] out_ccw_second_x,
  input logic signed [cotp_pkg::COORD_W-1:0] out_ccw_second_y,
  input logic                                out_degenerate
);

  // Once out of reset the block always takes a transaction
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy raised outside reset");

  // Every result strobe traces back to an accepted transaction
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, cotp_pkg::LATENCY))
    else $error("result without matching transaction");

  // A degenerate result carries all-zero points
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |->
      (out_cw_first_x == '0) && (out_cw_first_y == '0) &&
      (out_cw_second_x == '0) && (out_cw_second_y == '0) &&
      (out_ccw_first_x == '0) && (out_ccw_first_y == '0) &&
      (out_ccw_second_x == '0) && (out_ccw_second_y == '0))
    else $error("degenerate result with non-zero point");

endmodule

bind circle_outer_tangent_points cotp_checker u_cotp_checker (.*);

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for circle_outer_tangent_points: directed and random circle pairs.
// Depends on cotp_pkg and the circle_outer_tangent_points RTL only.
`default_nettype none

module tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SAT_HI = (1 << (cotp_pkg::COORD_W - 1)) - 1;
  localparam int SAT_LO = -(1 << (cotp_pkg::COORD_W - 1));

  typedef struct packed {
    logic signed [cotp_pkg::COORD_W-1:0] c1x;
    logic signed [cotp_pkg::COORD_W-1:0] c1y;
    logic [cotp_pkg::RAD_W-1:0]          r1;
    logic signed [cotp_pkg::COORD_W-1:0] c2x;
    logic signed [cotp_pkg::COORD_W-1:0] c2y;
    logic [cotp_pkg::RAD_W-1:0]          r2;
  } circle_pair_t;

  typedef struct packed {
    logic signed [cotp_pkg::COORD_W-1:0] cw1x, cw1y, cw2x, cw2y;
    logic signed [cotp_pkg::COORD_W-1:0] ccw1x, ccw1y, ccw2x, ccw2y;
    logic                                degen;
  } tangent_pts_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  circle_pair_t drv = '0;
  tangent_pts_t got;
  logic out_valid;

  circle_pair_t pending_pairs[$];
  tangent_pts_t expected_pts[$];
  int mismatches = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_degen = 0;
  int idle_cycles = 0;
  int gap = 0;
  bit stim_done = 1'b0;

  circle_outer_tangent_points u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_first_center_x(drv.c1x), .in_first_center_y(drv.c1y),
    .in_first_radius(drv.r1),
    .in_second_center_x(drv.c2x), .in_second_center_y(drv.c2y),
    .in_second_radius(drv.r2),
    .out_valid(out_valid),
    .out_cw_first_x(got.cw1x), .out_cw_first_y(got.cw1y),
    .out_cw_second_x(got.cw2x), .out_cw_second_y(got.cw2y),
    .out_ccw_first_x(got.ccw1x), .out_ccw_first_y(got.ccw1y),
    .out_ccw_second_x(got.ccw2x), .out_ccw_second_y(got.ccw2y),
    .out_degenerate(got.degen)
  );

  // Clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Q30 quotient of num/den truncated toward zero, by restoring division
  function automatic longint q30_ratio(longint num, longint unsigned den);
    longint unsigned rem;
    longint unsigned q;
    rem = (num < 0) ? longint'(-num) : longint'(num);
    q = 0;
    if (rem >= den) begin
      rem -= den;
      q = 1;
    end
    for (int i = 0; i < cotp_pkg::UNIT_BITS; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem -= den;
        q |= 1;
      end
    end
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // centre + round_half_away(radius * unit / 2^30), saturated
  function automatic logic signed [cotp_pkg::COORD_W-1:0] touch_coord(longint ctr,
      longint unsigned rad, longint unit);
    longint unsigned prod;
    longint v;
    prod = rad * ((unit < 0) ? longint'(-unit) : longint'(unit));
    prod = (prod + (64'd1 << (cotp_pkg::UNIT_BITS - 1))) >> cotp_pkg::UNIT_BITS;
    v = ctr + ((unit < 0) ? -longint'(prod) : longint'(prod));
    if (v > SAT_HI) v = SAT_HI;
    if (v < SAT_LO) v = SAT_LO;
    return v[cotp_pkg::COORD_W-1:0];
  endfunction

  function automatic tangent_pts_t predict_tangents(circle_pair_t p);
    tangent_pts_t t;
    longint dx, dy, dr, sx, sy, sr, sh;
    longint unsigned ax, ay, ar, mx, d2, h;
    longint ccw0, ccw1, cw0, cw1;
    t = '0;
    dx = longint'(p.c2x) - longint'(p.c1x);
    dy = longint'(p.c2y) - longint'(p.c1y);
    dr = longint'({1'b0, p.r1}) - longint'({1'b0, p.r2});
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    ar = (dr < 0) ? -dr : dr;
    if (ax == 0 && ay == 0) begin
      t.degen = 1'b1;
      return t;
    end
    mx = (ax > ay) ? ax : ay;
    if (ar > mx) mx = ar;
    // normalise so the largest magnitude lies in [2^30, 2^31)
    while (mx < (64'd1 << 30)) begin
      mx = mx << 1; ax = ax << 1; ay = ay << 1; ar = ar << 1;
    end
    while (mx >= (64'd1 << 31)) begin
      mx = mx >> 1; ax = ax >> 1; ay = ay >> 1; ar = ar >> 1;
    end
    d2 = ax * ax + ay * ay;
    if (d2 == 0 || ar * ar > d2) begin
      t.degen = 1'b1;
      return t;
    end
    h = int_sqrt(d2 - ar * ar);
    sx = (dx < 0) ? -longint'(ax) : longint'(ax);
    sy = (dy < 0) ? -longint'(ay) : longint'(ay);
    sr = (dr < 0) ? -longint'(ar) : longint'(ar);
    sh = longint'(h);
    ccw0 = q30_ratio(sx * sr - sy * sh, d2);
    ccw1 = q30_ratio(sx * sh + sy * sr, d2);
    cw0 = q30_ratio(sx * sr + sy * sh, d2);
    cw1 = q30_ratio(sy * sr - sx * sh, d2);
    t.cw1x = touch_coord(p.c1x, p.r1, cw0);
    t.cw1y = touch_coord(p.c1y, p.r1, cw1);
    t.cw2x = touch_coord(p.c2x, p.r2, cw0);
    t.cw2y = touch_coord(p.c2y, p.r2, cw1);
    t.ccw1x = touch_coord(p.c1x, p.r1, ccw0);
    t.ccw1y = touch_coord(p.c1y, p.r1, ccw1);
    t.ccw2x = touch_coord(p.c2x, p.r2, ccw0);
    t.ccw2y = touch_coord(p.c2y, p.r2, ccw1);
    return t;
  endfunction

  function automatic int short_or_long_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic circle_pair_t random_pair();
    circle_pair_t p;
    int kind;
    p = ($bits(circle_pair_t))'({$urandom, $urandom, $urandom, $urandom, $urandom});
    kind = $urandom_range(0, 9);
    if (kind < 5) begin
      // modest geometry, mostly valid tangents
      p.c1x = 24'($signed(20'($urandom)));
      p.c1y = 24'($signed(20'($urandom)));
      p.c2x = 24'($signed(20'($urandom)));
      p.c2y = 24'($signed(20'($urandom)));
      p.r1 = 23'(18'($urandom));
      p.r2 = 23'(18'($urandom));
    end else if (kind == 5) begin
      // tiny separations exercise the left normalisation
      p.c2x = p.c1x + 24'($signed(4'($urandom)));
      p.c2y = p.c1y + 24'($signed(4'($urandom)));
      p.r1 = 23'(4'($urandom));
      p.r2 = 23'(4'($urandom));
    end else if (kind == 6) begin
      // radius gap equal to the distance along an axis
      p.c1y = 24'($signed(20'($urandom)));
      p.c2y = p.c1y;
      p.c1x = 24'($signed(20'($urandom)));
      p.r2 = 23'(18'($urandom));
      p.r1 = p.r2 + 23'(18'($urandom));
      p.c2x = p.c1x + $signed({1'b0, p.r1 - p.r2});
    end
    return p;
  endfunction

  // Stimulus
  initial begin
    circle_pair_t p;
    p = '0;
    // coincident centres, with and without radii
    pending_pairs.push_back(p);
    p.r1 = 23'd100; p.r2 = 23'd7;
    pending_pairs.push_back(p);
    // separate circles, equal radii
    p = '0; p.c2x = 24'sd2560; p.r1 = 23'd256; p.r2 = 23'd256;
    pending_pairs.push_back(p);
    // one circle inside the other: radius gap above distance
    p = '0; p.c2x = 24'sd10; p.r1 = 23'd1000; p.r2 = 23'd10;
    pending_pairs.push_back(p);
    // radius gap equal to distance, both signs
    p = '0; p.c2x = 24'sd500; p.r1 = 23'd600; p.r2 = 23'd100;
    pending_pairs.push_back(p);
    p = '0; p.c2y = -24'sd500; p.r1 = 23'd100; p.r2 = 23'd600;
    pending_pairs.push_back(p);
    // extreme corners, full radii: saturation both ways
    p.c1x = 24'(SAT_LO); p.c1y = 24'(SAT_LO); p.c2x = 24'(SAT_HI); p.c2y = 24'(SAT_HI);
    p.r1 = '1; p.r2 = '1;
    pending_pairs.push_back(p);
    p.c1x = 24'(SAT_HI); p.c1y = 24'(SAT_LO); p.c2x = 24'(SAT_LO); p.c2y = 24'(SAT_HI);
    p.r1 = '1; p.r2 = '0;
    pending_pairs.push_back(p);
    p.c1x = 24'(SAT_HI); p.c1y = 24'(SAT_HI); p.c2x = 24'(SAT_HI - 1); p.c2y = 24'(SAT_HI);
    p.r1 = '0; p.r2 = 23'd1;
    pending_pairs.push_back(p);
    p.c1x = 24'(SAT_LO); p.c1y = '0; p.c2x = 24'(SAT_LO); p.c2y = 24'sd1;
    p.r1 = '1; p.r2 = '1;
    pending_pairs.push_back(p);
    p.c1x = '0; p.c1y = 24'(SAT_HI); p.c2x = '0; p.c2y = 24'(SAT_LO);
    p.r1 = '1; p.r2 = 23'h2aaaaa;
    pending_pairs.push_back(p);
    p.c1x = -24'sd3; p.c1y = 24'sd4; p.c2x = '0; p.c2y = '0;
    p.r1 = '0; p.r2 = '0;
    pending_pairs.push_back(p);
    for (int i = 0; i < 400; i++) pending_pairs.push_back(random_pair());
  end

  // Hold reset at start, then release it
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Driver: presents the next pair; a pair is taken on start & !busy
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        expected_pts.push_back(predict_tangents(drv));
        n_accepted++;
      end
      if (start && busy) begin
        // hold the current transaction
      end else if (gap > 0) begin
        gap <= gap - 1;
        start <= 1'b0;
      end else if (pending_pairs.size() > 0) begin
        drv <= pending_pairs.pop_front();
        start <= 1'b1;
        gap <= short_or_long_gap();
      end else begin
        start <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  // Monitor: compare each strobe with the oldest expectation
  always @(posedge clk) begin
    tangent_pts_t want;
    if (rst_n && out_valid) begin
      if (expected_pts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", got);
      end else begin
        want = expected_pts.pop_front();
        n_checked++;
        if (want.degen) n_degen++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: expected %p, got %p", n_checked, want, got);
        end
      end
    end
  end

  // Watchdog and end of run
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (stim_done && expected_pts.size() == 0 && idle_cycles > cotp_pkg::LATENCY + 20) begin
      $display("checked %0d circle pairs (%0d degenerate) against %0d sent",
               n_checked, n_degen, n_accepted);
      if (mismatches == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
    end else if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_pts.size());
      $display("simulation failed");
      $finish;
    end
  end

endmodule

`default_nettype wire
